[design/obu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package obu_pkg;

   localparam int LVL_IDX_W = 6;
   localparam int PRICE_W   = 64;
   localparam int KEY_W     = 64;
   localparam int AMT_W     = 31;
   localparam int TOTAL_W   = 41;
   localparam int DELTA_W   = 33;
   localparam int ORD_OUT_W = 11;

   typedef enum logic [2:0] {
      REQ_ADD      = 3'd0,
      REQ_MODIFY   = 3'd1,
      REQ_CANCEL   = 3'd2,
      REQ_TRADE    = 3'd3,
      REQ_CLEAR    = 3'd4,
      REQ_SNAPSHOT = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_PLAN,
      ST_LSRCH,
      ST_LACT,
      ST_SNAP
   } st_type;

   typedef enum logic [2:0] {
      LVA_NONE,
      LVA_TAKE,
      LVA_SLOT,
      LVA_ADJ,
      LVA_CLEAR
   } lvl_act_type;

   typedef enum logic [2:0] {
      STEP_0    = 3'd0,
      STEP_1    = 3'd1,
      STEP_2    = 3'd2,
      STEP_3    = 3'd3,
      STEP_4    = 3'd4,
      STEP_DONE = 3'd7
   } step_type;

   typedef struct packed {
      lvl_act_type                 act;
      logic                        side;
      logic [LVL_IDX_W-1:0]        idx;
      logic                        hit;
      logic [LVL_IDX_W-1:0]        pos;
      logic [PRICE_W-1:0]          price;
      logic [AMT_W-1:0]            amt;
      logic signed [DELTA_W-1:0]   delta;
   } lvl_cmd_type;

   typedef struct packed {
      logic               used;
      logic               is_ask;
      logic [AMT_W-1:0]   amount;
      logic [PRICE_W-1:0] price;
      logic [KEY_W-1:0]   key;
   } ent_type;

endpackage

`default_nettype wire

[design/obu_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module obu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[design/obu_levels.sv]
`timescale 1ns / 1ps
`default_nettype none

module obu_levels import obu_pkg::*; #(
   parameter int MAX_LEVELS = 32,
   parameter int CNT_W      = 11
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lvl_cmd_type          cmd,
   output logic [PRICE_W-1:0]        rd_price,
   output logic [TOTAL_W-1:0]        rd_total,
   output logic [CNT_W-1:0]          rd_count,
   output logic [LVL_IDX_W-1:0]      used_bid,
   output logic [LVL_IDX_W-1:0]      used_ask
);

   localparam int LA_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   logic [PRICE_W-1:0]   price_ff [2][MAX_LEVELS];
   logic [PRICE_W-1:0]   price_in [2][MAX_LEVELS];
   logic [TOTAL_W-1:0]   total_ff [2][MAX_LEVELS];
   logic [TOTAL_W-1:0]   total_in [2][MAX_LEVELS];
   logic [CNT_W-1:0]     count_ff [2][MAX_LEVELS];
   logic [CNT_W-1:0]     count_in [2][MAX_LEVELS];
   logic [LVL_IDX_W-1:0] used_ff  [2];
   logic [LVL_IDX_W-1:0] used_in  [2];

   logic [LA_W-1:0]  sel;
   logic [LA_W-1:0]  psel;
   logic             s;
   logic [CNT_W-1:0] cnt_dec;

   assign sel      = cmd.idx[LA_W-1:0];
   assign psel     = cmd.pos[LA_W-1:0];
   assign s        = cmd.side;
   assign rd_price = price_ff[s][sel];
   assign rd_total = total_ff[s][sel];
   assign rd_count = count_ff[s][sel];
   assign used_bid = used_ff[0];
   assign used_ask = used_ff[1];

   always_comb begin
      price_in = price_ff;
      total_in = total_ff;
      count_in = count_ff;
      used_in  = used_ff;
      cnt_dec  = (count_ff[s][sel] != '0) ? count_ff[s][sel] - CNT_W'(1) : '0;
      case (cmd.act)
         LVA_TAKE: begin
            if (cmd.hit) begin
               if (cnt_dec == '0) begin
                  // close the gap left by the emptied level
                  for (int i = 0; i < MAX_LEVELS - 1; i++) begin
                     if (LVL_IDX_W'(i) >= cmd.idx) begin
                        price_in[s][i] = price_ff[s][i+1];
                        total_in[s][i] = total_ff[s][i+1];
                        count_in[s][i] = count_ff[s][i+1];
                     end
                  end
                  used_in[s] = used_ff[s] - LVL_IDX_W'(1);
               end else begin
                  total_in[s][sel] = total_ff[s][sel] - TOTAL_W'(cmd.amt);
                  count_in[s][sel] = cnt_dec;
               end
            end
         end
         LVA_SLOT: begin
            if (cmd.hit) begin
               total_in[s][sel] = total_ff[s][sel] + TOTAL_W'(cmd.amt);
               count_in[s][sel] = count_ff[s][sel] + CNT_W'(1);
            end else if (used_ff[s] < LVL_IDX_W'(MAX_LEVELS)) begin
               for (int i = 1; i < MAX_LEVELS; i++) begin
                  if (LVL_IDX_W'(i) > cmd.pos) begin
                     price_in[s][i] = price_ff[s][i-1];
                     total_in[s][i] = total_ff[s][i-1];
                     count_in[s][i] = count_ff[s][i-1];
                  end
               end
               price_in[s][psel] = cmd.price;
               total_in[s][psel] = TOTAL_W'(cmd.amt);
               count_in[s][psel] = CNT_W'(1);
               used_in[s]        = used_ff[s] + LVL_IDX_W'(1);
            end
         end
         LVA_ADJ: begin
            if (cmd.hit) begin
               total_in[s][sel] = total_ff[s][sel]
                  + {{(TOTAL_W-DELTA_W){cmd.delta[DELTA_W-1]}}, cmd.delta};
            end
         end
         LVA_CLEAR: begin
            used_in[0] = '0;
            used_in[1] = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff[0] <= '0;
         used_ff[1] <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      total_ff <= total_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

[design/order_book_by_order_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Market-by-order book with one order table in RAM and sorted price levels per side.
// Add, modify, cancel and trade scan the order table one entry per cycle,
// then run up to three level searches, each walking the side's levels one per
// cycle; the order table scan dominates an event. Clear, and reset, run a
// clearing pass over every order table entry, during which no request is taken.
// A snapshot returns one result per cycle while the result side keeps up, apart
// from a pause when it turns from the bid side to the ask side. req_ready is
// high only between events.
module order_book_by_order_unit import obu_pkg::*; #(
   parameter int MAX_ORDERS = 1024,
   parameter int MAX_LEVELS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [2:0]           req_type,
   input  wire logic [63:0]          req_order_id,
   input  wire logic                 req_side,
   input  wire logic signed [63:0]   req_price,
   input  wire logic [30:0]          req_qty,
   input  wire logic signed [63:0]   req_new_price,
   input  wire logic signed [31:0]   req_new_qty,
   input  wire logic [5:0]           req_levels_wanted,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_level_side,
   output logic signed [63:0]        rsp_level_price,
   output logic [40:0]               rsp_level_qty,
   output logic [10:0]               rsp_level_orders,
   output logic                      rsp_level_valid,
   output logic                      rsp_last_level,
   output logic                      rsp_book_overflow
);

   localparam int AW    = $clog2(MAX_ORDERS);
   localparam int CNT_W = $clog2(MAX_ORDERS + 1);

   st_type                 state_ff, state_in;
   step_type               step_ff, step_in;
   req_code_type           op_ff, op_in;
   logic [KEY_W-1:0]       id_ff, id_in;
   logic                   side_ff, side_in;
   logic [PRICE_W-1:0]     p_ff, p_in;
   logic [AMT_W-1:0]       q_ff, q_in;
   logic [PRICE_W-1:0]     np_ff, np_in;
   logic                   keep_ff, keep_in;
   logic [AMT_W-1:0]       nq_ff, nq_in;
   logic [LVL_IDX_W-1:0]   want_ff, want_in;

   logic [AW-1:0]          sc_ff, sc_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_addr_ff, pend_addr_in;

   logic                   e_found_ff, e_found_in;
   logic [AW-1:0]          e_idx_ff, e_idx_in;
   logic [PRICE_W-1:0]     e_price_ff, e_price_in;
   logic [AMT_W-1:0]       e_amt_ff, e_amt_in;
   logic                   e_ask_ff, e_ask_in;
   logic                   fr_found_ff, fr_found_in;
   logic [AW-1:0]          fr_idx_ff, fr_idx_in;

   logic                   s_side_ff, s_side_in;
   logic [PRICE_W-1:0]     s_price_ff, s_price_in;
   lvl_act_type            lop_ff, lop_in;
   logic [AMT_W-1:0]       amt_ff, amt_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [LVL_IDX_W-1:0]   li_ff, li_in;
   logic                   hit_ff, hit_in;
   logic [LVL_IDX_W-1:0]   pos_ff, pos_in;
   logic                   pos_set_ff, pos_set_in;
   logic                   fail_ff, fail_in;
   logic [LVL_IDX_W-1:0]   lim_b_ff, lim_b_in;
   logic [LVL_IDX_W-1:0]   lim_a_ff, lim_a_in;
   logic                   ovf_ff, ovf_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   o_side_ff, o_side_in;
   logic [PRICE_W-1:0]     o_price_ff, o_price_in;
   logic [TOTAL_W-1:0]     o_qty_ff, o_qty_in;
   logic [ORD_OUT_W-1:0]   o_orders_ff, o_orders_in;
   logic                   o_lvalid_ff, o_lvalid_in;
   logic                   o_last_ff, o_last_in;
   logic                   o_ovf_ff, o_ovf_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   ent_type                ram_wdata;
   logic [AW-1:0]          ram_raddr;
   ent_type                ram_rdata;

   lvl_cmd_type            cmd;
   logic [PRICE_W-1:0]     lv_rd_price;
   logic [TOTAL_W-1:0]     lv_rd_total;
   logic [CNT_W-1:0]       lv_rd_count;
   logic [LVL_IDX_W-1:0]   used_b;
   logic [LVL_IDX_W-1:0]   used_a;
   logic [LVL_IDX_W-1:0]   used_s;
   logic [CNT_W+ORD_OUT_W-1:0] cnt_ext;

   logic                   srch_go;
   logic                   srch_side;
   logic [PRICE_W-1:0]     srch_price;
   lvl_act_type            srch_act;
   logic [AMT_W-1:0]       srch_amt;
   logic signed [DELTA_W-1:0] srch_delta;
   logic                   wr_go;
   logic [AW-1:0]          wr_addr;
   logic                   wr_used;
   logic [PRICE_W-1:0]     wr_price;
   logic [AMT_W-1:0]       wr_amt;
   logic                   wr_ask;

   logic [AW-1:0]          fidx;
   logic                   out_free;
   logic                   ahead;
   logic                   snap_last;

   obu_ram #(
      .WIDTH ($bits(ent_type)),
      .DEPTH (MAX_ORDERS)
   ) u_orders (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   obu_levels #(
      .MAX_LEVELS (MAX_LEVELS),
      .CNT_W      (CNT_W)
   ) u_levels (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_price (lv_rd_price),
      .rd_total (lv_rd_total),
      .rd_count (lv_rd_count),
      .used_bid (used_b),
      .used_ask (used_a)
   );

   assign used_s   = s_side_ff ? used_a : used_b;
   assign cnt_ext  = (CNT_W+ORD_OUT_W)'(lv_rd_count);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ahead    = s_side_ff ? ($signed(s_price_ff) < $signed(lv_rd_price))
                               : ($signed(s_price_ff) > $signed(lv_rd_price));
   assign fidx     = (e_found_ff && (!fr_found_ff || e_idx_ff < fr_idx_ff)) ? e_idx_ff
                                                                        : fr_idx_ff;
   assign snap_last = s_side_ff ? (li_ff + LVL_IDX_W'(1) == lim_a_ff)
                                : ((li_ff + LVL_IDX_W'(1) == lim_b_ff) && lim_a_ff == '0);

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_side    = o_side_ff;
   assign rsp_level_price   = o_price_ff;
   assign rsp_level_qty     = o_qty_ff;
   assign rsp_level_orders  = o_orders_ff;
   assign rsp_level_valid   = o_lvalid_ff;
   assign rsp_last_level    = o_last_ff;
   assign rsp_book_overflow = o_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      side_in      = side_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      np_in        = np_ff;
      keep_in      = keep_ff;
      nq_in        = nq_ff;
      want_in      = want_ff;
      sc_in        = sc_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      e_found_in   = e_found_ff;
      e_idx_in     = e_idx_ff;
      e_price_in   = e_price_ff;
      e_amt_in     = e_amt_ff;
      e_ask_in     = e_ask_ff;
      fr_found_in  = fr_found_ff;
      fr_idx_in    = fr_idx_ff;
      s_side_in    = s_side_ff;
      s_price_in   = s_price_ff;
      lop_in       = lop_ff;
      amt_in       = amt_ff;
      delta_in     = delta_ff;
      li_in        = li_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      pos_set_in   = pos_set_ff;
      fail_in      = fail_ff;
      lim_b_in     = lim_b_ff;
      lim_a_in     = lim_a_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      o_side_in    = o_side_ff;
      o_price_in   = o_price_ff;
      o_qty_in     = o_qty_ff;
      o_orders_in  = o_orders_ff;
      o_lvalid_in  = o_lvalid_ff;
      o_last_in    = o_last_ff;
      o_ovf_in     = o_ovf_ff;

      ram_we    = 1'b0;
      ram_waddr = sc_ff;
      ram_wdata = '0;
      ram_raddr = sc_ff;

      cmd.act   = LVA_NONE;
      cmd.side  = s_side_ff;
      cmd.idx   = li_ff;
      cmd.hit   = hit_ff;
      cmd.pos   = pos_ff;
      cmd.price = s_price_ff;
      cmd.amt   = amt_ff;
      cmd.delta = delta_ff;

      srch_go    = 1'b0;
      srch_side  = e_ask_ff;
      srch_price = e_price_ff;
      srch_act   = LVA_TAKE;
      srch_amt   = e_amt_ff;
      srch_delta = '0;
      wr_go      = 1'b0;
      wr_addr    = e_idx_ff;
      wr_used    = 1'b0;
      wr_price   = e_price_ff;
      wr_amt     = e_amt_ff;
      wr_ask     = e_ask_ff;

      // check the entry read in the previous scan cycle
      if (pend_ff) begin
         if (ram_rdata.used && ram_rdata.key == id_ff && !e_found_ff) begin
            e_found_in = 1'b1;
            e_idx_in   = pend_addr_ff;
            e_price_in = ram_rdata.price;
            e_amt_in   = ram_rdata.amount;
            e_ask_in   = ram_rdata.is_ask;
         end
         if (!ram_rdata.used && !fr_found_ff) begin
            fr_found_in = 1'b1;
            fr_idx_in   = pend_addr_ff;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = sc_ff;
            ram_wdata = '0;
            sc_in     = sc_ff + AW'(1);
            if (sc_ff == AW'(MAX_ORDERS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_code_type'(req_type);
               id_in   = req_order_id;
               side_in = req_side;
               p_in    = req_price;
               q_in    = req_qty;
               np_in   = (req_new_price == '0) ? req_price : req_new_price;
               keep_in = req_new_qty[31];
               nq_in   = (req_new_qty == '0) ? req_qty : req_new_qty[30:0];
               want_in = req_levels_wanted;
               case (req_type)
                  REQ_ADD, REQ_MODIFY, REQ_CANCEL, REQ_TRADE: begin
                     state_in    = ST_SCAN;
                     sc_in       = '0;
                     e_found_in  = 1'b0;
                     fr_found_in = 1'b0;
                     step_in     = STEP_0;
                  end
                  REQ_CLEAR: begin
                     state_in = ST_INIT;
                     sc_in    = '0;
                     ovf_in   = 1'b0;
                     cmd.act  = LVA_CLEAR;
                  end
                  REQ_SNAPSHOT: begin
                     lim_b_in  = (used_b < req_levels_wanted) ? used_b : req_levels_wanted;
                     lim_a_in  = (used_a < req_levels_wanted) ? used_a : req_levels_wanted;
                     li_in     = '0;
                     s_side_in = 1'b0;
                     state_in  = ST_SNAP;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            ram_raddr    = sc_ff;
            pend_in      = 1'b1;
            pend_addr_in = sc_ff;
            sc_in        = sc_ff + AW'(1);
            if (sc_ff == AW'(MAX_ORDERS - 1)) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = ST_IDLE;
            case (op_ff)
               REQ_ADD: begin
                  case (step_ff)
                     STEP_0: begin
                        state_in = ST_PLAN;
                        step_in  = STEP_1;
                        srch_go  = e_found_ff;
                     end
                     STEP_1: begin
                        if (!(e_found_ff || fr_found_ff)) begin
                           ovf_in = 1'b1;
                           wr_go  = e_found_ff;
                        end else begin
                           srch_go    = 1'b1;
                           srch_side  = side_ff;
                           srch_price = p_ff;
                           srch_act   = LVA_SLOT;
                           srch_amt   = q_ff;
                           step_in    = STEP_2;
                        end
                     end
                     STEP_2: begin
                        if (fail_ff) begin
                           ovf_in = 1'b1;
                           wr_go  = e_found_ff;
                        end else begin
                           // free the old entry when the new one lands elsewhere
                           wr_go    = e_found_ff && (e_idx_ff != fidx);
                           state_in = ST_PLAN;
                           step_in  = STEP_3;
                        end
                     end
                     STEP_3: begin
                        wr_go    = 1'b1;
                        wr_addr  = fidx;
                        wr_used  = 1'b1;
                        wr_price = p_ff;
                        wr_amt   = q_ff;
                        wr_ask   = side_ff;
                     end
                     default: ;
                  endcase
               end
               REQ_MODIFY: begin
                  if (e_found_ff) begin
                     case (step_ff)
                        STEP_0: begin
                           state_in = ST_PLAN;
                           if (np_ff != e_price_ff) begin
                              srch_go = 1'b1;
                              step_in = STEP_1;
                           end else begin
                              step_in = STEP_3;
                           end
                        end
                        STEP_1: begin
                           srch_go    = 1'b1;
                           srch_price = np_ff;
                           srch_act   = LVA_SLOT;
                           step_in    = STEP_2;
                        end
                        STEP_2: begin
                           srch_go  = 1'b1;
                           srch_act = LVA_SLOT;
                           if (fail_ff) begin
                              // put the order back at its old level
                              ovf_in  = 1'b1;
                              step_in = STEP_DONE;
                           end else begin
                              srch_go    = 1'b0;
                              e_price_in = np_ff;
                              state_in   = ST_PLAN;
                              step_in    = STEP_3;
                           end
                        end
                        STEP_3: begin
                           state_in = ST_PLAN;
                           step_in  = STEP_4;
                           if (!keep_ff) begin
                              srch_go    = 1'b1;
                              srch_act   = LVA_ADJ;
                              srch_delta = $signed({2'b00, nq_ff}) - $signed({2'b00, e_amt_ff});
                              e_amt_in   = nq_ff;
                           end
                        end
                        STEP_4: begin
                           wr_go   = 1'b1;
                           wr_used = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
               REQ_CANCEL: begin
                  if (e_found_ff) begin
                     case (step_ff)
                        STEP_0: begin
                           srch_go = 1'b1;
                           step_in = STEP_1;
                        end
                        STEP_1: begin
                           wr_go = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
               REQ_TRADE: begin
                  if (e_found_ff) begin
                     case (step_ff)
                        STEP_0: begin
                           srch_go = 1'b1;
                           if (q_ff >= e_amt_ff) begin
                              step_in = STEP_1;
                           end else begin
                              srch_act   = LVA_ADJ;
                              srch_delta = -$signed({2'b00, q_ff});
                              e_amt_in   = e_amt_ff - q_ff;
                              step_in    = STEP_2;
                           end
                        end
                        STEP_1: begin
                           wr_go = 1'b1;
                        end
                        STEP_2: begin
                           wr_go   = 1'b1;
                           wr_used = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
         ST_LSRCH: begin
            if (li_ff == used_s) begin
               hit_in   = 1'b0;
               state_in = ST_LACT;
               if (!pos_set_ff) begin
                  pos_in = li_ff;
               end
            end else if (lv_rd_price == s_price_ff) begin
               hit_in   = 1'b1;
               state_in = ST_LACT;
            end else begin
               if (!pos_set_ff && ahead) begin
                  pos_in     = li_ff;
                  pos_set_in = 1'b1;
               end
               li_in = li_ff + LVL_IDX_W'(1);
            end
         end
         ST_LACT: begin
            cmd.act = lop_ff;
            if (lop_ff == LVA_SLOT && !hit_ff && used_s >= LVL_IDX_W'(MAX_LEVELS)) begin
               fail_in = 1'b1;
            end
            state_in = ST_PLAN;
         end
         ST_SNAP: begin
            if (out_free) begin
               if (lim_b_ff == '0 && lim_a_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  o_side_in    = 1'b0;
                  o_price_in   = '0;
                  o_qty_in     = '0;
                  o_orders_in  = '0;
                  o_lvalid_in  = 1'b0;
                  o_last_in    = 1'b1;
                  o_ovf_in     = ovf_ff;
                  state_in     = ST_IDLE;
               end else if (!s_side_ff && li_ff == lim_b_ff) begin
                  s_side_in = 1'b1;
                  li_in     = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  o_side_in    = s_side_ff;
                  o_price_in   = lv_rd_price;
                  o_qty_in     = lv_rd_total;
                  o_orders_in  = cnt_ext[ORD_OUT_W-1:0];
                  o_lvalid_in  = 1'b1;
                  o_last_in    = snap_last;
                  o_ovf_in     = ovf_ff;
                  li_in        = li_ff + LVL_IDX_W'(1);
                  if (snap_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (srch_go) begin
         s_side_in  = srch_side;
         s_price_in = srch_price;
         lop_in     = srch_act;
         amt_in     = srch_amt;
         delta_in   = srch_delta;
         li_in      = '0;
         hit_in     = 1'b0;
         pos_set_in = 1'b0;
         fail_in    = 1'b0;
         state_in   = ST_LSRCH;
      end

      if (wr_go) begin
         ram_we           = 1'b1;
         ram_waddr        = wr_addr;
         ram_wdata.used   = wr_used;
         ram_wdata.is_ask = wr_ask;
         ram_wdata.amount = wr_amt;
         ram_wdata.price  = wr_price;
         ram_wdata.key    = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sc_ff        <= '0;
         pend_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         pend_ff      <= pend_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      op_ff        <= op_in;
      id_ff        <= id_in;
      side_ff      <= side_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      np_ff        <= np_in;
      keep_ff      <= keep_in;
      nq_ff        <= nq_in;
      want_ff      <= want_in;
      pend_addr_ff <= pend_addr_in;
      e_found_ff   <= e_found_in;
      e_idx_ff     <= e_idx_in;
      e_price_ff   <= e_price_in;
      e_amt_ff     <= e_amt_in;
      e_ask_ff     <= e_ask_in;
      fr_found_ff  <= fr_found_in;
      fr_idx_ff    <= fr_idx_in;
      s_side_ff    <= s_side_in;
      s_price_ff   <= s_price_in;
      lop_ff       <= lop_in;
      amt_ff       <= amt_in;
      delta_ff     <= delta_in;
      li_ff        <= li_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      pos_set_ff   <= pos_set_in;
      fail_ff      <= fail_in;
      lim_b_ff     <= lim_b_in;
      lim_a_ff     <= lim_a_in;
      o_side_ff    <= o_side_in;
      o_price_ff   <= o_price_in;
      o_qty_ff     <= o_qty_in;
      o_orders_ff  <= o_orders_in;
      o_lvalid_ff  <= o_lvalid_in;
      o_last_ff    <= o_last_in;
      o_ovf_ff     <= o_ovf_in;
   end

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_CLEAR)
      |=> (used_b == '0 && used_a == '0 && !ovf_ff))
      else $error("clear left levels or overflow flag behind");

   a_full_slot_fails: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LACT && lop_ff == LVA_SLOT && !hit_ff
       && used_s >= LVL_IDX_W'(MAX_LEVELS))
      |=> fail_ff)
      else $error("level insert on a full side not flagged");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LSRCH) |-> (li_ff <= used_s))
      else $error("level search ran past the used levels");

   a_rsp_from_snap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SNAP))
      else $error("result raised outside a snapshot");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import obu_pkg::*;

   localparam int ORDER_SLOTS = 1024;
   localparam int LEVEL_SLOTS = 32;
   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;
   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;
   localparam logic signed [63:0] PX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PX_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [30:0] QTY_MAX = 31'h7FFF_FFFF;
   localparam logic [63:0] ID_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]          kind;
      logic [63:0]         id;
      logic                side;
      logic signed [63:0]  price;
      logic [30:0]         qty;
      logic signed [63:0]  new_price;
      logic signed [31:0]  new_qty;
      logic [5:0]          depth;
   } book_event_t;

   typedef struct packed {
      logic                side;
      logic signed [63:0]  price;
      logic [40:0]         qty;
      logic [10:0]         orders;
      logic                valid;
      logic                last;
      logic                ovf;
   } level_rsp_t;

   typedef struct packed {
      book_event_t ev;
      logic        empty_snap;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = '0;
   logic [63:0] req_order_id = '0;
   logic req_side = 1'b0;
   logic signed [63:0] req_price = '0;
   logic [30:0] req_qty = '0;
   logic signed [63:0] req_new_price = '0;
   logic signed [31:0] req_new_qty = '0;
   logic [5:0] req_levels_wanted = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_level_side;
   logic signed [63:0] rsp_level_price;
   logic [40:0] rsp_level_qty;
   logic [10:0] rsp_level_orders;
   logic rsp_level_valid;
   logic rsp_last_level;
   logic rsp_book_overflow;

   order_book_by_order_unit dut (.*);

   always #2 clock = ~clock;

   // book mirror
   bit                 ent_used [ORDER_SLOTS];
   logic [63:0]        ent_key  [ORDER_SLOTS];
   logic signed [63:0] ent_px   [ORDER_SLOTS];
   logic [30:0]        ent_amt  [ORDER_SLOTS];
   bit                 ent_ask  [ORDER_SLOTS];
   logic signed [63:0] lv_px  [2][LEVEL_SLOTS];
   logic [63:0]        lv_tot [2][LEVEL_SLOTS];
   int                 lv_cnt [2][LEVEL_SLOTS];
   int                 lv_n [2];
   bit                 book_ovf;

   level_rsp_t expected_levels[$];
   int errors = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   logic [63:0] id_pool [24];
   logic signed [63:0] px_pool [12];

   function automatic int level_find(bit s, logic signed [63:0] p);
      for (int i = 0; i < lv_n[s]; i++)
         if (lv_px[s][i] == p) return i;
      return -1;
   endfunction

   function automatic int level_slot(bit s, logic signed [63:0] p);
      int f;
      int pos;
      f = level_find(s, p);
      if (f >= 0) return f;
      if (lv_n[s] >= LEVEL_SLOTS) return -1;
      pos = 0;
      while (pos < lv_n[s] && !(s ? (p < lv_px[s][pos]) : (p > lv_px[s][pos]))) pos++;
      for (int i = lv_n[s]; i > pos; i--) begin
         lv_px[s][i] = lv_px[s][i-1];
         lv_tot[s][i] = lv_tot[s][i-1];
         lv_cnt[s][i] = lv_cnt[s][i-1];
      end
      lv_px[s][pos] = p;
      lv_tot[s][pos] = '0;
      lv_cnt[s][pos] = 0;
      lv_n[s]++;
      return pos;
   endfunction

   function automatic void level_put(bit s, int i, logic [30:0] amt);
      lv_tot[s][i] += amt;
      lv_cnt[s][i] += 1;
   endfunction

   function automatic void level_take(bit s, logic signed [63:0] p, logic [30:0] amt);
      int f;
      f = level_find(s, p);
      if (f < 0) return;
      lv_tot[s][f] -= amt;
      if (lv_cnt[s][f] > 0) lv_cnt[s][f] -= 1;
      if (lv_cnt[s][f] != 0) return;
      for (int i = f; i + 1 < lv_n[s]; i++) begin
         lv_px[s][i] = lv_px[s][i+1];
         lv_tot[s][i] = lv_tot[s][i+1];
         lv_cnt[s][i] = lv_cnt[s][i+1];
      end
      lv_n[s]--;
   endfunction

   function automatic int order_find(logic [63:0] id);
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (ent_used[i] && ent_key[i] == id) return i;
      return -1;
   endfunction

   function automatic void order_drop(int e);
      level_take(ent_ask[e], ent_px[e], ent_amt[e]);
      ent_used[e] = 1'b0;
   endfunction

   function automatic void book_clear();
      foreach (ent_used[i]) ent_used[i] = 1'b0;
      lv_n[0] = 0;
      lv_n[1] = 0;
      book_ovf = 1'b0;
   endfunction

   // update the mirror for one event and queue the snapshot levels it yields
   function automatic void book_apply(book_event_t ev);
      int e;
      int lv;
      bit s;
      bit keep;
      logic signed [63:0] np;
      logic [30:0] nq;
      level_rsp_t snap[$];
      level_rsp_t r;
      int lim;
      case (ev.kind)
         REQ_ADD: begin
            e = order_find(ev.id);
            if (e >= 0) order_drop(e);
            for (e = 0; e < ORDER_SLOTS && ent_used[e]; e++) ;
            if (e >= ORDER_SLOTS) begin
               book_ovf = 1'b1;
               return;
            end
            lv = level_slot(ev.side, ev.price);
            if (lv < 0) begin
               book_ovf = 1'b1;
               return;
            end
            level_put(ev.side, lv, ev.qty);
            ent_used[e] = 1'b1;
            ent_key[e] = ev.id;
            ent_px[e] = ev.price;
            ent_amt[e] = ev.qty;
            ent_ask[e] = ev.side;
         end
         REQ_MODIFY: begin
            np = (ev.new_price == 0) ? ev.price : ev.new_price;
            keep = ev.new_qty < 0;
            nq = (ev.new_qty == 0) ? ev.qty : ev.new_qty[30:0];
            e = order_find(ev.id);
            if (e < 0) return;
            s = ent_ask[e];
            if (np != ent_px[e]) begin
               level_take(s, ent_px[e], ent_amt[e]);
               lv = level_slot(s, np);
               if (lv < 0) begin
                  lv = level_slot(s, ent_px[e]);
                  if (lv >= 0) level_put(s, lv, ent_amt[e]);
                  book_ovf = 1'b1;
                  return;
               end
               level_put(s, lv, ent_amt[e]);
               ent_px[e] = np;
            end
            if (!keep) begin
               lv = level_find(s, ent_px[e]);
               if (lv >= 0) lv_tot[s][lv] = lv_tot[s][lv] - ent_amt[e] + nq;
               ent_amt[e] = nq;
            end
         end
         REQ_CANCEL: begin
            e = order_find(ev.id);
            if (e >= 0) order_drop(e);
         end
         REQ_TRADE: begin
            e = order_find(ev.id);
            if (e < 0) return;
            if (ev.qty >= ent_amt[e]) begin
               order_drop(e);
               return;
            end
            s = ent_ask[e];
            ent_amt[e] -= ev.qty;
            lv = level_find(s, ent_px[e]);
            if (lv >= 0) lv_tot[s][lv] -= ev.qty;
         end
         REQ_CLEAR: book_clear();
         REQ_SNAPSHOT: begin
            for (int sd = 0; sd < 2; sd++) begin
               lim = (lv_n[sd] > ev.depth) ? ev.depth : lv_n[sd];
               for (int i = 0; i < lim; i++) begin
                  r.side = sd[0];
                  r.price = lv_px[sd][i];
                  r.qty = lv_tot[sd][i][40:0];
                  r.orders = lv_cnt[sd][i][10:0];
                  r.valid = 1'b1;
                  r.last = 1'b0;
                  r.ovf = book_ovf;
                  snap.push_back(r);
               end
            end
            if (snap.size() == 0) begin
               r = '0;
               r.ovf = book_ovf;
               snap.push_back(r);
            end
            snap[snap.size()-1].last = 1'b1;
            foreach (snap[i]) expected_levels.push_back(snap[i]);
         end
         default: ;
      endcase
   endfunction

   task automatic issue(book_event_t ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_type = ev.kind;
      req_order_id = ev.id;
      req_side = ev.side;
      req_price = ev.price;
      req_qty = ev.qty;
      req_new_price = ev.new_price;
      req_new_qty = ev.new_qty;
      req_levels_wanted = ev.depth;
      req_valid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      book_apply(ev);
      @(negedge clock);
   endtask

   function automatic book_event_t random_event();
      book_event_t ev;
      int pick;
      ev.kind = REQ_SNAPSHOT;
      pick = $urandom_range(99);
      if (pick < 26) ev.kind = REQ_ADD;
      else if (pick < 42) ev.kind = REQ_MODIFY;
      else if (pick < 54) ev.kind = REQ_CANCEL;
      else if (pick < 69) ev.kind = REQ_TRADE;
      else if (pick < 72) ev.kind = REQ_CLEAR;
      else if (pick < 73) ev.kind = ($urandom_range(1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
      ev.id = ($urandom_range(9) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(23)];
      ev.side = $urandom_range(1);
      ev.price = ($urandom_range(9) == 0) ? {$urandom, $urandom} : px_pool[$urandom_range(11)];
      ev.qty = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200);
      pick = $urandom_range(9);
      if (pick < 3) ev.new_price = '0;
      else if (pick < 9) ev.new_price = px_pool[$urandom_range(11)];
      else ev.new_price = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick < 3) ev.new_qty = '0;
      else if (pick < 5) ev.new_qty = $urandom | 32'h8000_0000;
      else if (pick < 7) ev.new_qty = $urandom & 32'h7FFF_FFFF;
      else ev.new_qty = $urandom_range(300);
      ev.depth = $urandom_range(32);
      return ev;
   endfunction

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         level_rsp_t got;
         level_rsp_t want;
         got = {rsp_level_side, rsp_level_price, rsp_level_qty, rsp_level_orders,
                rsp_level_valid, rsp_last_level, rsp_book_overflow};
         if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t: unexpected level side=%0d px=%0d qty=%0d n=%0d v=%0d last=%0d ovf=%0d",
                     $time, got.side, got.price, got.qty, got.orders, got.valid, got.last,
                     got.ovf);
         end else begin
            want = expected_levels.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: level mismatch expected side=%0d px=%0d qty=%0d n=%0d v=%0d last=%0d ovf=%0d",
                        $time, want.side, want.price, want.qty, want.orders, want.valid,
                        want.last, want.ovf);
               $display("%0t:                 actual side=%0d px=%0d qty=%0d n=%0d v=%0d last=%0d ovf=%0d",
                        $time, got.side, got.price, got.qty, got.orders, got.valid,
                        got.last, got.ovf);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("testbench failed");
      $finish;
   end

   initial begin
      directed_row_t dir_rows[$];
      book_event_t ev;
      level_rsp_t empty_level;
      bit fill_side;

      book_clear();
      foreach (id_pool[i]) id_pool[i] = (i < 18) ? 64'(i) : {$urandom, $urandom};
      id_pool[18] = ID_MAX;
      foreach (px_pool[i]) px_pool[i] = 64'(i) * 5 - 20;
      px_pool[0] = PX_MIN;
      px_pool[11] = PX_MAX;

      ev = '0;
      ev.kind = REQ_SNAPSHOT; ev.depth = 6'd32;
      dir_rows.push_back({ev, 1'b1});
      ev = '0;
      ev.kind = REQ_ADD; ev.id = '0; ev.side = SIDE_BID; ev.price = PX_MAX; ev.qty = QTY_MAX;
      dir_rows.push_back({ev, 1'b0});
      ev.id = ID_MAX; ev.side = SIDE_ASK; ev.price = PX_MIN; ev.qty = 31'd1;
      dir_rows.push_back({ev, 1'b0});
      ev.id = 64'd5; ev.side = SIDE_BID; ev.price = -64'sd1; ev.qty = 31'd100;
      dir_rows.push_back({ev, 1'b0});
      // same id again replaces the resting order
      ev.side = SIDE_ASK; ev.price = 64'sd7; ev.qty = 31'd3;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_SNAPSHOT; ev.depth = 6'd1;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_MODIFY; ev.id = 64'd5; ev.price = 64'sd9; ev.qty = 31'd50;
      dir_rows.push_back({ev, 1'b0});
      ev.new_price = 64'sd11; ev.new_qty = -32'sd1;
      dir_rows.push_back({ev, 1'b0});
      ev.new_price = '0; ev.price = 64'sd11; ev.new_qty = '0; ev.qty = '0;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_TRADE; ev.id = '0; ev.qty = 31'd10;
      dir_rows.push_back({ev, 1'b0});
      ev.id = 64'd99;
      dir_rows.push_back({ev, 1'b0});
      ev.kind = REQ_CANCEL; ev.id = 64'd77;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_ADD; ev.id = 64'd6; ev.side = SIDE_ASK; ev.price = 64'sd11; ev.qty = 31'd4;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_SNAPSHOT; ev.depth = 6'd32;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_TRADE; ev.id = 64'd6; ev.qty = QTY_MAX;
      dir_rows.push_back({ev, 1'b0});
      ev.kind = REQ_CANCEL; ev.id = ID_MAX;
      dir_rows.push_back({ev, 1'b0});
      ev = '1;
      ev.kind = REQ_SPARE_LO;
      dir_rows.push_back({ev, 1'b0});
      ev.kind = REQ_SPARE_HI;
      dir_rows.push_back({ev, 1'b0});
      ev = '0;
      ev.kind = REQ_SNAPSHOT; ev.depth = 6'd0;
      dir_rows.push_back({ev, 1'b0});
      ev.kind = REQ_CLEAR;
      dir_rows.push_back({ev, 1'b0});
      ev.kind = REQ_SNAPSHOT; ev.depth = 6'd32;
      dir_rows.push_back({ev, 1'b1});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      empty_level = '0;
      empty_level.last = 1'b1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].empty_snap) begin
            // empty book: one invalid level marked last, no overflow
            issue(dir_rows[i].ev);
            void'(expected_levels.pop_back());
            expected_levels.push_back(empty_level);
         end else begin
            issue(dir_rows[i].ev);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 85 : 0;
         rcv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 10 : 0;
         // hold until the book has drained its results
         req_valid = 1'b0;
         while (expected_levels.size() != 0) @(negedge clock);

         // fill one side past its level capacity, then push a modify off the end
         fill_side = $urandom_range(1);
         for (int k = 0; k < LEVEL_SLOTS + 2; k++) begin
            ev = random_event();
            ev.kind = REQ_ADD;
            ev.id = 64'd1000 + k;
            ev.side = fill_side;
            ev.price = 64'sd1000 + (fill_side ? k : -k) * 3;
            issue(ev);
         end
         ev = random_event();
         ev.kind = REQ_MODIFY;
         ev.id = 64'd1003;
         ev.new_price = 64'sd5000;
         issue(ev);
         ev.kind = REQ_SNAPSHOT;
         ev.depth = 6'd32;
         issue(ev);

         for (int n = 0; n < 115; n++) issue(random_event());
      end

      req_valid = 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (errors == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule
